@@ sv/aga_pkg.sv @@
// Shared types, reset constants and score helpers for the affine-gap aligner.
package aga_pkg;

    // Working width for score arithmetic before saturation.
    localparam int WIDE = 18;
    // Width of a length index handed to the gap-boundary helper.
    localparam int KW = 7;

    localparam logic signed [5:0] OPEN_PEN_RST = -6'sd10;
    localparam logic signed [4:0] EXT_PEN_RST  = -5'sd1;
    localparam logic [3:0]        MATCH_RST    = 4'd2;
    localparam logic signed [4:0] MISMATCH_RST = -5'sd1;

    localparam logic [1:0] REG_OPEN_PEN = 2'd0;
    localparam logic [1:0] REG_EXT_PEN  = 2'd1;
    localparam logic [1:0] REG_MATCH    = 2'd2;
    localparam logic [1:0] REG_MISMATCH = 2'd3;

    typedef struct packed {
        logic signed [5:0] open_pen;
        logic signed [4:0] ext_pen;
        logic [3:0]        match;
        logic signed [4:0] mismatch;
    } cfg_t;

    // Clamp to a signed w-bit range.
    function automatic logic signed [WIDE-1:0] sat_w(input logic signed [WIDE-1:0] v,
                                                     input int w);
        logic signed [WIDE-1:0] hi;
        logic signed [WIDE-1:0] lo;
        hi = $signed((WIDE'(1) << (w - 1)) - WIDE'(1));
        lo = -hi - WIDE'(1);
        if (v > hi)
            return hi;
        else if (v < lo)
            return lo;
        return v;
    endfunction

    // Unsaturated edge score for a gap of length k: open + (k-1)*extend.
    function automatic logic signed [WIDE-1:0] bnd_raw(input logic [KW-1:0] k,
                                                       input cfg_t c);
        logic signed [WIDE-1:0] km1;
        km1 = $signed(WIDE'(k)) - WIDE'(1);
        return WIDE'(c.open_pen) + km1 * WIDE'(c.ext_pen);
    endfunction

    // Diagonal term for a symbol pair.
    function automatic logic signed [WIDE-1:0] diag_term(input logic [7:0] a,
                                                         input logic [7:0] b,
                                                         input cfg_t c);
        if (a == b)
            return $signed(WIDE'(c.match));
        return WIDE'(c.mismatch);
    endfunction

endpackage

@@ sv/aga_cell.sv @@
// One row cell of the systolic fill array: holds a first-sequence symbol and its matrix row.
module aga_cell
    import aga_pkg::*;
#(
    parameter int SW      = 12,
    parameter int MAX_LEN = 32,
    parameter int IDX     = 1
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cfg_t                               cfg,
    input  logic                               init,
    input  logic                               ld,
    input  logic [7:0]                         ld_sym,
    input  logic                               in_v,
    input  logic [7:0]                         in_b,
    input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] in_addr,
    input  logic signed [SW-1:0]               in_s,
    input  logic signed [SW-1:0]               in_vg,
    output logic                               out_v,
    output logic [7:0]                         out_b,
    output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] out_addr,
    output logic signed [SW-1:0]               out_s,
    output logic signed [SW-1:0]               out_vg,
    input  logic [$clog2(MAX_LEN+1)-1:0]       tb_i,
    input  logic [$clog2(MAX_LEN+1)-1:0]       tb_j,
    output logic signed [SW-1:0]               rd_s,
    output logic signed [SW-1:0]               rd_h,
    output logic [7:0]                         sym
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);

    logic [7:0]               sym_reg;
    logic signed [SW-1:0]     left_s_reg;
    logic signed [SW-1:0]     left_h_reg;
    logic signed [SW-1:0]     diag_reg;
    logic                     out_v_reg;
    logic [7:0]               out_b_reg;
    logic [AW-1:0]            out_addr_reg;
    logic signed [SW-1:0]     out_s_reg;
    logic signed [SW-1:0]     out_vg_reg;
    logic [2*SW-1:0]          mem [MAX_LEN];
    logic [2*SW-1:0]          rd_reg;

    logic signed [WIDE-1:0]   h_w;
    logic signed [WIDE-1:0]   v_w;
    logic signed [WIDE-1:0]   d_w;
    logic signed [SW-1:0]     h_c;
    logic signed [SW-1:0]     v_c;
    logic signed [SW-1:0]     d_c;
    logic signed [SW-1:0]     s_c;
    logic signed [SW-1:0]     own_bnd;
    logic signed [SW-1:0]     up_bnd;
    logic [LW-1:0]            rd_row;
    logic [AW-1:0]            rd_addr;

    always_comb
    begin
        logic signed [WIDE-1:0] a0;
        logic signed [WIDE-1:0] a1;
        a0 = WIDE'(left_h_reg) + WIDE'(cfg.ext_pen);
        a1 = WIDE'(left_s_reg) + WIDE'(cfg.open_pen);
        h_w = sat_w((a0 > a1) ? a0 : a1, SW);
        a0 = WIDE'(in_vg) + WIDE'(cfg.ext_pen);
        a1 = WIDE'(in_s) + WIDE'(cfg.open_pen);
        v_w = sat_w((a0 > a1) ? a0 : a1, SW);
        d_w = sat_w(WIDE'(diag_reg) + diag_term(sym_reg, in_b, cfg), SW);
        h_c = SW'(h_w);
        v_c = SW'(v_w);
        d_c = SW'(d_w);
        s_c = (d_c > h_c) ? d_c : h_c;
        if (v_c > s_c)
            s_c = v_c;
    end

    assign own_bnd = SW'(sat_w(bnd_raw(KW'(IDX), cfg), SW));
    assign up_bnd  = (IDX == 1) ? '0 : SW'(sat_w(bnd_raw(KW'(IDX - 1), cfg), SW));

    always_ff @(posedge clk)
    begin
        if (ld)
            sym_reg <= ld_sym;
        if (init)
        begin
            left_s_reg <= own_bnd;
            left_h_reg <= own_bnd;
            diag_reg   <= up_bnd;
        end
        else if (in_v)
        begin
            left_s_reg <= s_c;
            left_h_reg <= h_c;
            diag_reg   <= in_s;
        end
        out_b_reg    <= in_b;
        out_addr_reg <= in_addr;
        out_s_reg    <= s_c;
        out_vg_reg   <= v_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= in_v;
    end

    // Traceback reads this row at column j, the row above it at column j-1.
    assign rd_row  = (tb_i == LW'(IDX)) ? (tb_j - LW'(1)) : (tb_j - LW'(2));
    assign rd_addr = rd_row[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (in_v)
            mem[in_addr] <= {s_c, h_c};
        rd_reg <= mem[rd_addr];
    end

    assign out_v    = out_v_reg;
    assign out_b    = out_b_reg;
    assign out_addr = out_addr_reg;
    assign out_s    = out_s_reg;
    assign out_vg   = out_vg_reg;
    assign rd_s     = rd_reg[2*SW-1:SW];
    assign rd_h     = rd_reg[SW-1:0];
    assign sym      = sym_reg;

endmodule

@@ sv/affine_gap_global_aligner_core.sv @@
// Affine-gap global aligner: a row of MAX_LEN cells fills the matrices in a wavefront, then
// traceback walks back from the corner. Symbols load at one beat per cycle while idle. The
// beat that closes the second sequence holds intake for the whole run: the fill streams the
// second sequence through the cell row, then traceback spends a cell-memory read state and a
// decision state on each output column. A run of n by m yields c columns, max(n,m) <= c <= n+m,
// and intake stays held through any output stall until the last column is issued.
module affine_gap_global_aligner_core
    import aga_pkg::*;
#(
    parameter int MAX_LEN     = 32,
    parameter int SCORE_WIDTH = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  symbol,
    input  logic        seq_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  top_symbol,
    output logic        top_is_gap,
    output logic [7:0]  bottom_symbol,
    output logic        bottom_is_gap,
    output logic [11:0] final_score,
    output logic        length_overflow,
    output logic        last_column
);

    localparam int SW = SCORE_WIDTH;
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(2 * MAX_LEN + 4);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FILL = 4'b0010,
        S_RD   = 4'b0100,
        S_DEC  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    cfg_t            cfg_reg;
    logic [LW-1:0]   first_len_reg;
    logic [LW-1:0]   second_len_reg;
    logic            ovf_reg;
    logic            run_ovf_reg;
    logic [LW-1:0]   n_reg;
    logic [LW-1:0]   m_reg;
    logic [LW-1:0]   i_reg;
    logic [LW-1:0]   j_reg;
    logic            first_reg;
    logic signed [SW-1:0] fs_reg;
    logic [CW-1:0]   cnt_reg;
    logic [7:0]      sec_reg [MAX_LEN];

    logic            feed_v_reg;
    logic [7:0]      feed_b_reg;
    logic [AW-1:0]   feed_addr_reg;
    logic signed [SW-1:0] feed_s_reg;

    logic            out_valid_reg;
    logic [7:0]      top_symbol_reg;
    logic            top_is_gap_reg;
    logic [7:0]      bottom_symbol_reg;
    logic            bottom_is_gap_reg;
    logic [11:0]     final_score_reg;
    logic            length_overflow_reg;
    logic            last_column_reg;

    logic            lnk_v    [MAX_LEN+1];
    logic [7:0]      lnk_b    [MAX_LEN+1];
    logic [AW-1:0]   lnk_addr [MAX_LEN+1];
    logic signed [SW-1:0] lnk_s  [MAX_LEN+1];
    logic signed [SW-1:0] lnk_vg [MAX_LEN+1];
    logic signed [SW-1:0] rd_s_arr [MAX_LEN];
    logic signed [SW-1:0] rd_h_arr [MAX_LEN];
    logic [7:0]      sym_arr  [MAX_LEN];
    logic [MAX_LEN-1:0] ld_vec;

    logic            in_acc;
    logic            out_free;
    logic            start;
    logic            fill_done;
    logic [AW-1:0]   sec_addr;
    logic [7:0]      sec_rd;
    logic signed [SW-1:0] feed_bnd;

    logic [LW-1:0]   im1;
    logic [LW-1:0]   im2;
    logic [LW-1:0]   jm1;
    logic [LW-1:0]   k1;
    logic [LW-1:0]   k2;
    logic signed [SW-1:0] b1;
    logic signed [SW-1:0] b2;
    logic signed [SW-1:0] sc_ij;
    logic signed [SW-1:0] hg_ij;
    logic signed [SW-1:0] diag_s;
    logic signed [SW-1:0] dsc;
    logic signed [SW-1:0] fs_now;
    logic signed [WIDE-1:0] fs_wide;
    logic [7:0]      a_sym;
    logic            take_diag;
    logic            take_h;
    logic [LW-1:0]   i_nx;
    logic [LW-1:0]   j_nx;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign start    = in_acc && opcode && seq_last;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_pen <= OPEN_PEN_RST;
            cfg_reg.ext_pen  <= EXT_PEN_RST;
            cfg_reg.match    <= MATCH_RST;
            cfg_reg.mismatch <= MISMATCH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OPEN_PEN: cfg_reg.open_pen <= cfg_data;
                REG_EXT_PEN:  cfg_reg.ext_pen  <= cfg_data[4:0];
                REG_MATCH:    cfg_reg.match    <= cfg_data[3:0];
                REG_MISMATCH: cfg_reg.mismatch <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Second-sequence store; one read port shared by fill and traceback.
    assign sec_addr = (state_reg == S_FILL) ? cnt_reg[AW-1:0] : jm1[AW-1:0];
    assign sec_rd   = sec_reg[sec_addr];

    always_ff @(posedge clk)
    begin
        if (in_acc && opcode && (second_len_reg < LW'(MAX_LEN)))
            sec_reg[second_len_reg[AW-1:0]] <= symbol;
    end

    always_comb
    begin
        for (int k = 0; k < MAX_LEN; k++)
            ld_vec[k] = in_acc && !opcode && (first_len_reg == LW'(k));
    end

    // Row-zero feed into the first cell.
    assign feed_bnd  = SW'(sat_w(bnd_raw(KW'(cnt_reg + CW'(1)), cfg_reg), SW));
    assign fill_done = (cnt_reg == CW'(m_reg) + CW'(MAX_LEN + 2));

    always_ff @(posedge clk)
    begin
        feed_b_reg    <= sec_rd;
        feed_addr_reg <= cnt_reg[AW-1:0];
        feed_s_reg    <= feed_bnd;
    end

    assign lnk_v[0]    = feed_v_reg;
    assign lnk_b[0]    = feed_b_reg;
    assign lnk_addr[0] = feed_addr_reg;
    assign lnk_s[0]    = feed_s_reg;
    assign lnk_vg[0]   = feed_s_reg;

    for (genvar g = 0; g < MAX_LEN; g++)
    begin : g_cell
        aga_cell #(
            .SW      (SW),
            .MAX_LEN (MAX_LEN),
            .IDX     (g + 1)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (cfg_reg),
            .init     (start),
            .ld       (ld_vec[g]),
            .ld_sym   (symbol),
            .in_v     (lnk_v[g]),
            .in_b     (lnk_b[g]),
            .in_addr  (lnk_addr[g]),
            .in_s     (lnk_s[g]),
            .in_vg    (lnk_vg[g]),
            .out_v    (lnk_v[g+1]),
            .out_b    (lnk_b[g+1]),
            .out_addr (lnk_addr[g+1]),
            .out_s    (lnk_s[g+1]),
            .out_vg   (lnk_vg[g+1]),
            .tb_i     (i_reg),
            .tb_j     (j_reg),
            .rd_s     (rd_s_arr[g]),
            .rd_h     (rd_h_arr[g]),
            .sym      (sym_arr[g])
        );
    end

    // Traceback decision on the cell read data.
    assign im1 = i_reg - LW'(1);
    assign im2 = i_reg - LW'(2);
    assign jm1 = j_reg - LW'(1);
    assign k1  = (i_reg == '0) ? j_reg : i_reg;
    assign k2  = (i_reg == LW'(1)) ? jm1 : im1;
    assign b1  = SW'(sat_w(bnd_raw(KW'(k1), cfg_reg), SW));
    assign b2  = SW'(sat_w(bnd_raw(KW'(k2), cfg_reg), SW));
    assign a_sym = sym_arr[im1[AW-1:0]];

    always_comb
    begin
        if (i_reg == '0 && j_reg == '0)
            sc_ij = '0;
        else if (i_reg == '0 || j_reg == '0)
            sc_ij = b1;
        else
            sc_ij = rd_s_arr[im1[AW-1:0]];
        hg_ij = (j_reg == '0) ? b1 : rd_h_arr[im1[AW-1:0]];
        if (i_reg == LW'(1) && j_reg == LW'(1))
            diag_s = '0;
        else if (i_reg == LW'(1) || j_reg == LW'(1))
            diag_s = b2;
        else
            diag_s = rd_s_arr[im2[AW-1:0]];
    end

    assign dsc = SW'(sat_w(WIDE'(diag_s) + diag_term(a_sym, sec_rd, cfg_reg), SW));
    assign take_diag = (i_reg != '0) && (j_reg != '0) && (sc_ij == dsc);
    assign take_h    = !take_diag && (j_reg != '0) && ((i_reg == '0) || (sc_ij == hg_ij));
    assign i_nx      = (take_diag || !take_h) ? im1 : i_reg;
    assign j_nx      = (take_diag || take_h) ? jm1 : j_reg;
    assign fs_now    = first_reg ? sc_ij : fs_reg;
    assign fs_wide   = WIDE'(fs_now);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = S_FILL;
            S_FILL: if (fill_done) state_next = S_RD;
            S_RD:   state_next = S_DEC;
            S_DEC:
            begin
                if (out_free)
                    state_next = (i_nx == '0 && j_nx == '0) ? S_IDLE : S_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            ovf_reg        <= 1'b0;
            feed_v_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            first_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (in_acc)
            begin
                if (!opcode)
                begin
                    if (first_len_reg < LW'(MAX_LEN))
                        first_len_reg <= first_len_reg + LW'(1);
                    else
                        ovf_reg <= 1'b1;
                end
                else if (second_len_reg < LW'(MAX_LEN))
                    second_len_reg <= second_len_reg + LW'(1);
                else
                    ovf_reg <= 1'b1;
            end
            if (start)
            begin
                first_len_reg  <= '0;
                second_len_reg <= '0;
                ovf_reg        <= 1'b0;
                cnt_reg        <= '0;
                first_reg      <= 1'b1;
            end
            if (state_reg == S_FILL)
            begin
                feed_v_reg <= (cnt_reg < CW'(m_reg));
                cnt_reg    <= cnt_reg + CW'(1);
            end
            else
                feed_v_reg <= 1'b0;
            if (state_reg == S_DEC && out_free)
            begin
                out_valid_reg <= 1'b1;
                first_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg       <= first_len_reg;
            m_reg       <= (second_len_reg < LW'(MAX_LEN)) ? second_len_reg + LW'(1)
                                                           : second_len_reg;
            run_ovf_reg <= ovf_reg || (second_len_reg >= LW'(MAX_LEN));
        end
        if (state_reg == S_FILL && fill_done)
        begin
            i_reg <= n_reg;
            j_reg <= m_reg;
        end
        if (state_reg == S_DEC && out_free)
        begin
            i_reg               <= i_nx;
            j_reg               <= j_nx;
            fs_reg              <= fs_now;
            top_symbol_reg      <= take_h ? 8'd0 : a_sym;
            top_is_gap_reg      <= take_h;
            bottom_symbol_reg   <= (take_diag || take_h) ? sec_rd : 8'd0;
            bottom_is_gap_reg   <= !(take_diag || take_h);
            final_score_reg     <= fs_wide[11:0];
            length_overflow_reg <= run_ovf_reg;
            last_column_reg     <= (i_nx == '0) && (j_nx == '0);
        end
    end

    assign out_valid       = out_valid_reg;
    assign top_symbol      = top_symbol_reg;
    assign top_is_gap      = top_is_gap_reg;
    assign bottom_symbol   = bottom_symbol_reg;
    assign bottom_is_gap   = bottom_is_gap_reg;
    assign final_score     = final_score_reg;
    assign length_overflow = length_overflow_reg;
    assign last_column     = last_column_reg;

    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state register not one-hot");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |=> !$rose(out_valid_reg))
        else $error("result beat raised during fill");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_DEC) |-> (i_reg <= n_reg && j_reg <= m_reg))
        else $error("traceback position outside the matrix");

    assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= LW'(MAX_LEN)) && (second_len_reg <= LW'(MAX_LEN)))
        else $error("sequence length beyond capacity");

endmodule

@@ tb/affine_gap_global_aligner_core_test.sv @@
// Self-checking testbench for the affine-gap global aligner core.
module affine_gap_global_aligner_core_test;
    import aga_pkg::*;

    localparam int MAXL = 32;
    localparam int DRAIN_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic       op;
        logic [7:0] sym;
        logic       last;
    } beat_t;

    typedef struct {
        logic [7:0]  top_symbol;
        logic        top_is_gap;
        logic [7:0]  bottom_symbol;
        logic        bottom_is_gap;
        logic [11:0] final_score;
        logic        length_overflow;
        logic        last_column;
    } column_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [5:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = 1'b0;
    logic [7:0]  symbol = '0;
    logic        seq_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  top_symbol;
    logic        top_is_gap;
    logic [7:0]  bottom_symbol;
    logic        bottom_is_gap;
    logic [11:0] final_score;
    logic        length_overflow;
    logic        last_column;

    affine_gap_global_aligner_core dut (.*);

    always #1 clk = ~clk;

    beat_t   pending_beats[$];
    column_t expected_cols[$];
    int      fail_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_cycles = 0;
    int      quiet_cycles = 0;
    bit      beat_taken = 0;

    // predictor state
    int         open_sc, gap_ext, match_sc, mismatch_sc;
    logic [7:0] first_syms[MAXL];
    logic [7:0] second_syms[MAXL];
    int         first_cnt = 0, second_cnt = 0;
    bit         dropped = 0;
    int         sc_m[MAXL+1][MAXL+1];
    int         hg_m[MAXL+1][MAXL+1];
    int         vg_m[MAXL+1][MAXL+1];

    function automatic int clamp12(int v);
        if (v > 2047) return 2047;
        if (v < -2048) return -2048;
        return v;
    endfunction

    function automatic int pair_score(int i, int j);
        return (first_syms[i-1] == second_syms[j-1]) ? match_sc : mismatch_sc;
    endfunction

    function automatic int max_of(int a, int b);
        return a > b ? a : b;
    endfunction

    task automatic align_and_queue();
        int n, m, i, j, h, v, d, cnt;
        column_t col;
        n = first_cnt;
        m = second_cnt;
        for (i = 0; i <= MAXL; i++)
            for (j = 0; j <= MAXL; j++)
            begin
                sc_m[i][j] = 0; hg_m[i][j] = 0; vg_m[i][j] = 0;
            end
        for (i = 1; i <= n; i++)
        begin
            hg_m[i][0] = clamp12(open_sc + (i - 1) * gap_ext);
            sc_m[i][0] = hg_m[i][0];
        end
        for (j = 1; j <= m; j++)
        begin
            vg_m[0][j] = clamp12(open_sc + (j - 1) * gap_ext);
            sc_m[0][j] = vg_m[0][j];
        end
        for (i = 1; i <= n; i++)
            for (j = 1; j <= m; j++)
            begin
                h = clamp12(max_of(hg_m[i][j-1] + gap_ext, sc_m[i][j-1] + open_sc));
                v = clamp12(max_of(vg_m[i-1][j] + gap_ext, sc_m[i-1][j] + open_sc));
                d = clamp12(sc_m[i-1][j-1] + pair_score(i, j));
                hg_m[i][j] = h;
                vg_m[i][j] = v;
                sc_m[i][j] = max_of(d, max_of(h, v));
            end
        col.final_score = 12'(sc_m[n][m]);
        col.length_overflow = dropped;
        i = n;
        j = m;
        cnt = 0;
        while ((i > 0 || j > 0) && cnt < 2 * MAXL)
        begin
            col.last_column = 1'b0;
            if (i > 0 && j > 0 &&
                sc_m[i][j] == clamp12(sc_m[i-1][j-1] + pair_score(i, j)))
            begin
                col.top_symbol = first_syms[i-1]; col.top_is_gap = 1'b0;
                col.bottom_symbol = second_syms[j-1]; col.bottom_is_gap = 1'b0;
                i--; j--;
            end
            else if (j > 0 && (i == 0 || sc_m[i][j] == hg_m[i][j]))
            begin
                col.top_symbol = '0; col.top_is_gap = 1'b1;
                col.bottom_symbol = second_syms[j-1]; col.bottom_is_gap = 1'b0;
                j--;
            end
            else
            begin
                col.top_symbol = first_syms[i-1]; col.top_is_gap = 1'b0;
                col.bottom_symbol = '0; col.bottom_is_gap = 1'b1;
                i--;
            end
            expected_cols.push_back(col);
            cnt++;
        end
        if (cnt > 0)
            expected_cols[expected_cols.size()-1].last_column = 1'b1;
        first_cnt = 0;
        second_cnt = 0;
        dropped = 0;
    endtask

    task automatic absorb_beat(beat_t b);
        if (!b.op)
        begin
            if (first_cnt < MAXL) first_syms[first_cnt++] = b.sym;
            else dropped = 1;
        end
        else
        begin
            if (second_cnt < MAXL) second_syms[second_cnt++] = b.sym;
            else dropped = 1;
            if (b.last) align_and_queue();
        end
    endtask

    // input driver: sample at rising edge, drive at falling edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            beat_t b;
            b.op = opcode; b.sym = symbol; b.last = seq_last;
            absorb_beat(b);
            beat_taken = 1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || beat_taken))
        begin
            beat_taken = 0;
            if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                beat_t b;
                b = pending_beats.pop_front();
                opcode <= b.op; symbol <= b.sym; seq_last <= b.last;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output side: stall pattern, long hold-off, and column check
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_cols.size() == 0)
            begin
                $error("unexpected column beat");
                fail_count++;
            end
            else
            begin
                column_t e;
                e = expected_cols.pop_front();
                if (top_symbol !== e.top_symbol)
                begin
                    $error("top_symbol exp %0d got %0d", e.top_symbol, top_symbol);
                    fail_count++;
                end
                if (top_is_gap !== e.top_is_gap)
                begin
                    $error("top_is_gap exp %0d got %0d", e.top_is_gap, top_is_gap);
                    fail_count++;
                end
                if (bottom_symbol !== e.bottom_symbol)
                begin
                    $error("bottom_symbol exp %0d got %0d", e.bottom_symbol, bottom_symbol);
                    fail_count++;
                end
                if (bottom_is_gap !== e.bottom_is_gap)
                begin
                    $error("bottom_is_gap exp %0d got %0d", e.bottom_is_gap, bottom_is_gap);
                    fail_count++;
                end
                if (final_score !== e.final_score)
                begin
                    $error("final_score exp %0d got %0d",
                           $signed(e.final_score), $signed(final_score));
                    fail_count++;
                end
                if (length_overflow !== e.length_overflow)
                begin
                    $error("length_overflow exp %0d got %0d",
                           e.length_overflow, length_overflow);
                    fail_count++;
                end
                if (last_column !== e.last_column)
                begin
                    $error("last_column exp %0d got %0d", e.last_column, last_column);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles with work outstanding but no beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (pending_beats.size() == 0 && !in_valid && expected_cols.size() == 0))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_OPEN_PEN: open_sc = $signed(val[5:0]);
            REG_EXT_PEN:  gap_ext = $signed(val[4:0]);
            REG_MATCH:    match_sc = int'(val[3:0]);
            REG_MISMATCH: mismatch_sc = $signed(val[4:0]);
            default: ;
        endcase
    endtask

    task automatic set_costs(logic [5:0] op, logic [5:0] ex, logic [5:0] ma, logic [5:0] mi);
        write_reg(REG_OPEN_PEN, op);
        write_reg(REG_EXT_PEN, ex);
        write_reg(REG_MATCH, ma);
        write_reg(REG_MISMATCH, mi);
    endtask

    task automatic add_beat(logic op, logic [7:0] sym, logic last);
        beat_t b;
        b.op = op; b.sym = sym; b.last = last;
        pending_beats.push_back(b);
    endtask

    function automatic logic [7:0] pick_sym(bit narrow);
        return narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    endfunction

    // one alignment job: n first symbols, m second symbols (m >= 1)
    task automatic add_job(int n, int m, bit narrow);
        for (int k = 0; k < n; k++)
            add_beat(1'b0, pick_sym(narrow), (k == n - 1) ? 1'($urandom_range(0, 1)) : 1'b0);
        for (int k = 0; k < m; k++)
            add_beat(1'b1, pick_sym(narrow), k == m - 1);
    endtask

    function automatic int job_len(bit allow_zero);
        if ($urandom_range(0, 14) == 0)
            return $urandom_range(30, 34);
        return $urandom_range(allow_zero ? 0 : 1, 8);
    endfunction

    task automatic settle();
        while (pending_beats.size() > 0 || in_valid || expected_cols.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(int sp, int rp, int budget);
        int queued, n, m;
        send_idle_pct = sp;
        recv_stall_pct = rp;
        queued = 0;
        while (queued < budget)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                n = job_len(1'b1);
                m = job_len(1'b0);
                add_job(n, m, 1'($urandom_range(0, 1)));
                queued += n + m;
            end
            else
            begin
                // stray beats that leave a run half built
                repeat ($urandom_range(1, 3))
                begin
                    if ($urandom_range(0, 1))
                        add_beat(1'b0, pick_sym(1'b0), 1'($urandom_range(0, 1)));
                    else
                        add_beat(1'b1, pick_sym(1'b0), 1'b0);
                    queued++;
                end
            end
        end
        add_job($urandom_range(0, 4), $urandom_range(1, 4), 1'b1);
        settle();
    endtask

    initial
    begin
        open_sc = int'(OPEN_PEN_RST);
        gap_ext = int'(EXT_PEN_RST);
        match_sc = int'(MATCH_RST);
        mismatch_sc = int'(MISMATCH_RST);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset costs, empty first sequence, edge symbols, overflow
        add_beat(1'b1, 8'd0, 1'b1);
        add_beat(1'b0, 8'd255, 1'b1);
        add_beat(1'b1, 8'd255, 1'b1);
        add_beat(1'b0, 8'd0, 1'b0);
        add_beat(1'b0, 8'd255, 1'b1);
        add_beat(1'b1, 8'd0, 1'b0);
        add_beat(1'b1, 8'd7, 1'b1);
        settle();
        for (int k = 0; k < 33; k++)
            add_beat(1'b0, 8'(k), 1'b0);
        add_beat(1'b1, 8'd5, 1'b1);
        settle();

        set_costs(6'h21, 6'h11, 6'h0F, 6'h11);  // costs one above the most negative, top bonus
        add_job(3, 4, 1'b1);
        settle();
        set_costs(6'h00, 6'h00, 6'h00, 6'h00);
        add_job(2, 3, 1'b1);
        settle();

        random_phase(0, 0, 50);
        set_costs(6'h1F, 6'h0F, 6'h0F, 6'h0F);  // largest positive costs
        random_phase(51, 0, 50);
        set_costs(6'($urandom_range(33, 63)), 6'($urandom_range(17, 31)),
                  6'($urandom_range(0, 15)), 6'($urandom_range(17, 31)));
        random_phase(0, 51, 50);
        set_costs(6'h21, 6'h11, 6'h0F, 6'h11);
        random_phase(11, 11, 50);

        // long receiver hold-off while the sender keeps offering beats
        set_costs(6'h36, 6'h1F, 6'h02, 6'h1F);
        hold_cycles = 400;
        random_phase(0, 0, 50);
        set_costs(6'($urandom_range(0, 63)), 6'($urandom_range(0, 31)),
                  6'($urandom_range(0, 15)), 6'($urandom_range(0, 31)));
        random_phase(0, 0, 50);

        if (fail_count == 0 && expected_cols.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ affine_gap_global_aligner_core.f @@
sv/aga_pkg.sv
sv/aga_cell.sv
sv/affine_gap_global_aligner_core.sv
tb/affine_gap_global_aligner_core_test.sv
